@@ rtl/sct_pkg.sv @@
// Types and constants for the sample count to time code converter.
// No dependencies; used by sample_count_to_timecode.
`timescale 1ns / 1ps

package sct_pkg;

    localparam int C_COUNT_WIDTH = 32;
    localparam int C_RATE_W      = 25;
    localparam int C_CFG_IDX_W   = 2;

    localparam logic [15:0] C_HOURS_MAX   = 16'hFFFF;
    localparam logic [21:0] C_MINUTES_MAX = 22'h3FFFFF;

    typedef enum logic [2:0] {
        FMT_SMPTE30  = 3'd0,
        FMT_HUNDRED  = 3'd1,
        FMT_THOUSAND = 3'd2,
        FMT_CD75     = 3'd3,
        FMT_HMS      = 3'd4,
        FMT_ZOOM     = 3'd5
    } t_fmt;

    typedef enum logic [2:0] {
        UNIT_30TH   = 3'd0,
        UNIT_100TH  = 3'd1,
        UNIT_1000TH = 3'd2,
        UNIT_75TH   = 3'd3,
        UNIT_NONE   = 3'd4
    } t_unit;

    typedef enum logic [1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_TIME_FORMAT = 2'd1,
        REG_ZOOM_SCALE  = 2'd2,
        REG_ZOOM_THRESH = 2'd3
    } t_reg_idx;

endpackage

@@ rtl/sct_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Self-contained; instantiated by sample_count_to_timecode.
`timescale 1ns / 1ps

module sct_div #(
    parameter int QW = 32,
    parameter int DW = 25,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [QW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [PW-1:0] o_side
);

    // Numerator bits shift out of the top of r_nq while quotient bits
    // shift in at the bottom.
    logic          r_vld  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_nq   [QW];
    logic [DW-1:0] r_den  [QW];
    logic [PW-1:0] r_side [QW];

    for (genvar gs = 0; gs < QW; gs++) begin : g_stage
        logic          w_vld;
        logic [DW-1:0] w_rem;
        logic [QW-1:0] w_nq;
        logic [DW-1:0] w_den;
        logic [PW-1:0] w_side;
        logic [DW:0]   w_try;
        logic [DW:0]   w_diff;
        logic          w_ge;
        logic [DW-1:0] n_rem;

        if (gs == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_rem  = '0;
            assign w_nq   = i_num;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[gs-1];
            assign w_rem  = r_rem[gs-1];
            assign w_nq   = r_nq[gs-1];
            assign w_den  = r_den[gs-1];
            assign w_side = r_side[gs-1];
        end

        assign w_try  = {w_rem, w_nq[QW-1]};
        assign w_ge   = (w_try >= {1'b0, w_den});
        assign w_diff = w_try - {1'b0, w_den};
        assign n_rem  = w_ge ? w_diff[DW-1:0] : w_try[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gs] <= 1'b0;
            end else if (i_en) begin
                r_vld[gs] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gs]  <= n_rem;
                r_nq[gs]   <= {w_nq[QW-2:0], w_ge};
                r_den[gs]  <= w_den;
                r_side[gs] <= w_side;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_nq[QW-1];
    assign o_rem  = r_rem[QW-1];
    assign o_side = r_side[QW-1];

endmodule

@@ rtl/sample_count_to_timecode.sv @@
// Top level of the sample count to time code converter.
// Depends on sct_pkg and sct_div.
`timescale 1ns / 1ps

//  Channel       Direction  Data                         Handshake
//  sample_count  in         i_sample_count               i_sample_count_valid / o_sample_count_ready
//  result        out        o_hours o_minutes o_seconds  o_result_valid / i_result_ready
//                           o_fraction o_fraction_unit
//  config        in         i_cfg_idx i_cfg_data         i_cfg_we, no wait
//
// One request is accepted per cycle while the output register is empty or being
// taken. The work is done by three chained bit-per-stage dividers: count / (3600
// or 60 times samples-per-second), the remainder by 60 * rate or rate, and a last
// divider for seconds or the fraction.
// Reset is synchronous and clears the valid bits and the configuration registers.
// The whole pipeline advances only when the output register is empty or being
// taken, so a stall freezes every stage and nothing is lost or repeated.

module sample_count_to_timecode
    import sct_pkg::*;
#(
    parameter int COUNT_WIDTH = C_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [C_RATE_W-1:0]    i_cfg_data,
    input  logic                   i_sample_count_valid,
    output logic                   o_sample_count_ready,
    input  logic [COUNT_WIDTH-1:0] i_sample_count,
    output logic                   o_result_valid,
    input  logic                   i_result_ready,
    output logic [15:0]            o_hours,
    output logic [21:0]            o_minutes,
    output logic [5:0]             o_seconds,
    output logic [9:0]             o_fraction,
    output logic [2:0]             o_fraction_unit
);

    localparam int D1W  = C_RATE_W + 12;
    localparam int D2W  = C_RATE_W + 6;
    localparam int RKW  = C_RATE_W + 10;
    localparam int D30W = C_RATE_W - 4;
    localparam int S1W  = 3 + C_RATE_W + D30W;
    localparam int S2W  = S1W + 16 + 22;
    localparam int S3W  = 3 + 16 + 22 + 6;

    localparam logic [11:0] C_SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  C_SECS_PER_MIN  = 6'd60;
    // Reciprocal of 30 scaled by 2^30, rounded up; exact for any 25-bit rate.
    localparam logic [25:0] C_RECIP30       = 26'd35791395;

    // Configuration registers.
    logic [24:0] r_sample_rate;
    logic [2:0]  r_time_format;
    logic [19:0] r_zoom_scale;
    logic [19:0] r_zoom_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= 25'd48000;
            r_time_format <= FMT_THOUSAND;
            r_zoom_scale  <= 20'd0;
            r_zoom_thresh <= 20'd512;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SAMPLE_RATE: r_sample_rate <= i_cfg_data;
                REG_TIME_FORMAT: r_time_format <= i_cfg_data[2:0];
                REG_ZOOM_SCALE:  r_zoom_scale  <= i_cfg_data[19:0];
                REG_ZOOM_THRESH: r_zoom_thresh <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register can take a new result.
    logic r_out_vld;
    logic w_en;
    assign w_en = !r_out_vld || i_result_ready;
    assign o_sample_count_ready = w_en;

    // Input decode: a zero rate acts as one, and the zoom-chosen format
    // resolves to hundredths or thousandths here.
    logic [24:0]         w_rate;
    logic [2:0]          w_unit;
    logic                w_hms0;
    logic [D1W-1:0]      w_den1;
    logic [C_RATE_W+25:0] w_d30_prod;
    logic [D30W-1:0]     w_d30;
    assign w_rate = (r_sample_rate == '0) ? 25'd1 : r_sample_rate;

    always_comb begin
        case (r_time_format) inside
            FMT_SMPTE30:  w_unit = UNIT_30TH;
            FMT_HUNDRED:  w_unit = UNIT_100TH;
            FMT_CD75:     w_unit = UNIT_75TH;
            FMT_HMS:      w_unit = UNIT_NONE;
            FMT_ZOOM:     w_unit = (r_zoom_scale >= r_zoom_thresh) ? UNIT_100TH : UNIT_1000TH;
            default:      w_unit = UNIT_1000TH;
        endcase
    end

    // The first divisor is samples per hour in h:m:s, else samples per minute.
    // The SMPTE frame divisor rate / 30 comes from a reciprocal multiply.
    assign w_hms0     = (w_unit == UNIT_NONE);
    assign w_den1     = w_hms0 ? D1W'(w_rate) * D1W'(C_SECS_PER_HOUR)
                               : D1W'(w_rate) * D1W'(C_SECS_PER_MIN);
    assign w_d30_prod = (C_RATE_W+26)'(w_rate) * (C_RATE_W+26)'(C_RECIP30);
    assign w_d30      = w_d30_prod[30 +: D30W];

    // Phase one: whole hours or whole minutes, and the sample remainder.
    logic                   w_v1;
    logic [COUNT_WIDTH-1:0] w_quo1;
    logic [D1W-1:0]         w_rem1;
    logic [S1W-1:0]         w_side1;

    sct_div #(.QW(COUNT_WIDTH), .DW(D1W), .PW(S1W)) u_div_big (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (i_sample_count_valid),
        .i_num  (i_sample_count),
        .i_den  (w_den1),
        .i_side ({w_unit, w_rate, w_d30}),
        .o_vld  (w_v1),
        .o_quo  (w_quo1),
        .o_rem  (w_rem1),
        .o_side (w_side1)
    );

    logic [2:0]      w_unit1;
    logic [24:0]     w_rate1;
    logic [D30W-1:0] w_d301;
    logic            w_hms1;
    logic [63:0]     w_quo1_x;
    logic [15:0]     w_hours_sat;
    logic [21:0]     w_mins_sat;
    logic [D2W-1:0]  w_den2;
    assign {w_unit1, w_rate1, w_d301} = w_side1;
    assign w_hms1      = (w_unit1 == UNIT_NONE);
    assign w_quo1_x    = 64'(w_quo1);
    assign w_hours_sat = (|w_quo1_x[63:16]) ? C_HOURS_MAX : w_quo1_x[15:0];
    assign w_mins_sat  = (|w_quo1_x[63:22]) ? C_MINUTES_MAX : w_quo1_x[21:0];
    assign w_den2      = w_hms1 ? D2W'(w_rate1) * D2W'(C_SECS_PER_MIN) : D2W'(w_rate1);

    // Phase two: minutes within the hour in h:m:s, else seconds within the minute.
    logic           w_v2;
    logic [D1W-1:0] w_quo2;
    logic [D2W-1:0] w_rem2;
    logic [S2W-1:0] w_side2;

    sct_div #(.QW(D1W), .DW(D2W), .PW(S2W)) u_div_mid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_v1),
        .i_num  (w_rem1),
        .i_den  (w_den2),
        .i_side ({w_unit1, w_rate1, w_d301, w_hours_sat, w_mins_sat}),
        .o_vld  (w_v2),
        .o_quo  (w_quo2),
        .o_rem  (w_rem2),
        .o_side (w_side2)
    );

    logic [2:0]      w_unit2;
    logic [24:0]     w_rate2;
    logic [D30W-1:0] w_d302;
    logic [15:0]     w_hours2;
    logic [21:0]     w_mins2;
    logic            w_hms2;
    logic [5:0]      w_sub2;
    logic [9:0]      w_scale;
    logic [RKW-1:0]  w_rk;
    logic [RKW-1:0]  w_num3;
    logic [24:0]     w_den3;
    assign {w_unit2, w_rate2, w_d302, w_hours2, w_mins2} = w_side2;
    assign w_hms2 = (w_unit2 == UNIT_NONE);
    // The quotient is below 60 in every format.
    assign w_sub2 = w_quo2[5:0];

    always_comb begin
        case (w_unit2)
            UNIT_100TH: w_scale = 10'd100;
            UNIT_75TH:  w_scale = 10'd75;
            default:    w_scale = 10'd1000;
        endcase
    end
    assign w_rk = RKW'(w_rem2[C_RATE_W-1:0]) * RKW'(w_scale);

    // The last divider gives seconds in h:m:s, else the fraction.
    always_comb begin
        case (w_unit2)
            UNIT_NONE: begin
                w_num3 = RKW'(w_rem2);
                w_den3 = w_rate2;
            end
            UNIT_30TH: begin
                w_num3 = RKW'(w_rem2);
                w_den3 = (w_d302 == '0) ? 25'd1 : 25'(w_d302);
            end
            default: begin
                w_num3 = w_rk;
                w_den3 = w_rate2;
            end
        endcase
    end

    logic           w_v3;
    logic [RKW-1:0] w_quo3;
    logic [24:0]    w_rem3;
    logic [S3W-1:0] w_side3;

    sct_div #(.QW(RKW), .DW(C_RATE_W), .PW(S3W)) u_div_last (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_v2),
        .i_num  (w_num3),
        .i_den  (w_den3),
        .i_side ({w_unit2, w_hours2, (w_hms2 ? 22'(w_sub2) : w_mins2), w_sub2}),
        .o_vld  (w_v3),
        .o_quo  (w_quo3),
        .o_rem  (w_rem3),
        .o_side (w_side3)
    );

    logic [2:0]  w_unit3;
    logic [15:0] w_hours3;
    logic [21:0] w_mins3;
    logic [5:0]  w_secs3;
    logic        w_hms;
    assign {w_unit3, w_hours3, w_mins3, w_secs3} = w_side3;
    assign w_hms = (w_unit3 == UNIT_NONE);

    // Output register.
    logic [15:0] r_hours;
    logic [21:0] r_minutes;
    logic [5:0]  r_seconds;
    logic [9:0]  r_fraction;
    logic [2:0]  r_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hours    <= w_hms ? w_hours3 : 16'd0;
            r_minutes  <= w_mins3;
            r_seconds  <= w_hms ? w_quo3[5:0] : w_secs3;
            r_fraction <= w_hms ? 10'd0 : w_quo3[9:0];
            r_unit     <= w_unit3;
        end
    end

    assign o_result_valid  = r_out_vld;
    assign o_hours         = r_hours;
    assign o_minutes       = r_minutes;
    assign o_seconds       = r_seconds;
    assign o_fraction      = r_fraction;
    assign o_fraction_unit = r_unit;

    // The reported unit is always one of the defined codes.
    a_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_fraction_unit <= UNIT_NONE)) else $error("bad fraction unit");

    // An empty output register never holds off new requests.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_sample_count_ready) else $error("ready low with empty output");

    // Seconds are always within the minute.
    a_secs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_seconds < 6'd60)) else $error("seconds out of range");

    // In h:m:s the minutes wrap and there is no fraction.
    a_hms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_fraction_unit == UNIT_NONE) |->
        (o_minutes < 22'd60 && o_fraction == 10'd0)) else $error("bad h:m:s result");

    // A result that waits keeps its minutes and fraction.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !i_result_ready) |=> $stable(o_minutes) && $stable(o_fraction))
        else $error("result changed while stalled");

endmodule
